// ----- design/mrg_pkg.sv -----
// mrg_pkg: shared types and constants of the maze row generator
// used by the controller, the datapath, the top level and the checker
`timescale 1ns / 1ps

package mrg_pkg;

	localparam int CFG_W   = 6;
	localparam int LABEL_W = 32;
	localparam int FLOOR_W = 32;
	localparam int SIDE_W  = 31;
	localparam int OP_W    = 2;

	localparam logic [OP_W-1:0] OP_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_MIDDLE = 2'd1;
	localparam logic [OP_W-1:0] OP_LAST   = 2'd2;
	localparam logic [OP_W-1:0] OP_SKIP   = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_OPEN,
		S_MERGE,
		S_HOLD
	} ctl_state_t;

	typedef enum logic [1:0] {
		P_NONE,
		P_FIRST,
		P_OPEN,
		P_MERGE
	} pass_t;

	typedef struct packed {
		logic  load;
		logic  step;
		pass_t pass;
		logic  publish;
	} ctl_cmd_t;

	typedef struct packed {
		logic last_step;
		logic out_free;
	} ctl_sts_t;

endpackage

// ----- design/mrg_ctrl.sv -----
// mrg_ctrl: sequencer for one row (capture, column passes, result hand-off)
// depends on mrg_pkg
`timescale 1ns / 1ps

module mrg_ctrl
	import mrg_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	input  ctl_sts_t        sts,
	output ctl_cmd_t        cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_op)
						OP_FIRST:           state_d = S_FIRST;
						OP_MIDDLE, OP_LAST: state_d = S_OPEN;
						default:            state_d = S_IDLE;
					endcase
				end
			end
			S_FIRST: if (sts.last_step) state_d = S_HOLD;
			S_OPEN:  if (sts.last_step) state_d = S_MERGE;
			S_MERGE: if (sts.last_step) state_d = S_HOLD;
			S_HOLD:  if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.pass    = P_NONE;
		cmd.publish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_FIRST: begin
				cmd.step = 1'b1;
				cmd.pass = P_FIRST;
			end
			S_OPEN: begin
				cmd.step = 1'b1;
				cmd.pass = P_OPEN;
			end
			S_MERGE: begin
				cmd.step = 1'b1;
				cmd.pass = P_MERGE;
			end
			S_HOLD:  cmd.publish = sts.out_free;
			default: in_ready = 1'b0;
		endcase
	end

endmodule

// ----- design/mrg_dp.sv -----
// mrg_dp: rotating column label register, label counter, wall accumulators
// and the result register; depends on mrg_pkg
`timescale 1ns / 1ps

module mrg_dp
	import mrg_pkg::*;
#(
	parameter int MAX_COLUMNS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic [OP_W-1:0]    in_op,
	input  logic [FLOOR_W-1:0] in_floor,
	input  logic [SIDE_W-1:0]  in_side,
	input  ctl_cmd_t           cmd,
	output ctl_sts_t           sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [FLOOR_W-1:0] out_floor,
	output logic [SIDE_W-1:0]  out_side
);

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	logic [LABEL_W-1:0]     lab_q [MAX_COLUMNS];
	logic [LABEL_W-1:0]     upd   [MAX_COLUMNS];
	logic [MAX_COLUMNS-1:0] use_q;
	logic [LABEL_W-1:0]     next_q, next_d;
	logic [LABEL_W-1:0]     run_q, run_d;
	logic                   opened_q, opened_d;
	logic                   merge_all_q;
	logic [CW-1:0]          cnt_q;
	logic [MAX_COLUMNS-1:0] frnd_q, srnd_q;
	logic [MAX_COLUMNS-1:0] floor_acc_q, side_acc_q;
	logic [CFG_W-1:0]       width_q, wc;
	logic [CFG_W-1:0]       k, kp1;
	logic                   active, more, at_last;
	logic                   fbit, sbit, f_wall, f_open;
	logic                   out_valid_q;
	logic [FLOOR_W-1:0]     out_floor_q;
	logic [SIDE_W-1:0]      out_side_q;

	// clamped column count
	always_comb begin
		if (width_q < CFG_W'(2))
			wc = CFG_W'(2);
		else if (width_q > CFG_W'(MAX_COLUMNS))
			wc = CFG_W'(MAX_COLUMNS);
		else
			wc = width_q;
	end

	assign k       = CFG_W'(cnt_q);
	assign kp1     = k + CFG_W'(1);
	assign active  = k < wc;
	assign more    = kp1 < wc;
	assign at_last = kp1 == wc;

	// column k sits at position 0, column k+1 at position 1
	always_comb begin
		upd      = lab_q;
		next_d   = next_q;
		run_d    = run_q;
		opened_d = opened_q;
		fbit     = 1'b0;
		sbit     = 1'b0;
		f_wall   = 1'b0;
		f_open   = opened_q;
		case (cmd.pass)
			P_FIRST: begin
				if (active) begin
					upd[0] = next_q;
					sbit   = more & srnd_q[0];
					if (at_last || sbit) next_d = next_q + LABEL_W'(1);
				end
			end
			P_OPEN: begin
				if (active) begin
					f_wall = frnd_q[0];
					f_open = opened_q | ~frnd_q[0];
					if (more && run_q != lab_q[1]) begin
						if (!f_open) f_wall = 1'b0;
						else f_open = 1'b0;
						run_d = lab_q[1];
					end
					if (at_last && !f_open) f_wall = 1'b0;
					if (f_wall) begin
						upd[0] = next_q;
						next_d = next_q + LABEL_W'(1);
					end
					opened_d = f_open;
					fbit     = f_wall;
				end
			end
			P_MERGE: begin
				if (active && more) begin
					if (lab_q[0] != lab_q[1]) begin
						sbit = ~merge_all_q & srnd_q[0];
						if (!sbit) begin
							for (int p = 0; p < MAX_COLUMNS; p++) begin
								if (use_q[p] && lab_q[p] == lab_q[1]) upd[p] = lab_q[0];
							end
						end
					end else begin
						sbit = 1'b1;
					end
				end
			end
			default: upd = lab_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_COLUMNS; p++) lab_q[p] <= '0;
			next_q   <= LABEL_W'(1);
			width_q  <= CFG_W'(32);
			cnt_q    <= '0;
			opened_q <= 1'b0;
		end else begin
			if (cfg_valid) width_q <= cfg_data;
			if (cmd.load) begin
				cnt_q    <= '0;
				opened_q <= 1'b0;
			end else if (cmd.step) begin
				for (int p = 0; p < MAX_COLUMNS - 1; p++) lab_q[p] <= upd[p+1];
				lab_q[MAX_COLUMNS-1] <= upd[0];
				next_q   <= next_d;
				opened_q <= opened_d;
				if (cnt_q == CW'(MAX_COLUMNS - 1)) cnt_q <= '0;
				else cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			run_q       <= lab_q[0];
			merge_all_q <= in_op == OP_LAST;
			frnd_q      <= in_floor[MAX_COLUMNS-1:0];
			srnd_q      <= {1'b0, in_side[MAX_COLUMNS-2:0]};
			floor_acc_q <= '0;
			side_acc_q  <= '0;
			for (int j = 0; j < MAX_COLUMNS; j++) use_q[j] <= CFG_W'(j) < wc;
		end else if (cmd.step) begin
			run_q <= run_d;
			use_q <= {use_q[0], use_q[MAX_COLUMNS-1:1]};
			if (cmd.pass == P_OPEN) begin
				frnd_q      <= frnd_q >> 1;
				floor_acc_q <= {fbit, floor_acc_q[MAX_COLUMNS-1:1]};
			end else begin
				srnd_q     <= srnd_q >> 1;
				side_acc_q <= {sbit, side_acc_q[MAX_COLUMNS-1:1]};
			end
		end
		if (cmd.publish) begin
			out_floor_q <= FLOOR_W'(floor_acc_q);
			out_side_q  <= SIDE_W'(side_acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.last_step = cnt_q == CW'(MAX_COLUMNS - 1);
	assign sts.out_free  = ~out_valid_q | out_ready;
	assign out_valid     = out_valid_q;
	assign out_floor     = out_floor_q;
	assign out_side      = out_side_q;

endmodule

// ----- design/maze_row_generator.sv -----
// channel   | signals                              | content
// s_axis    | s_axis_tvalid/tready/tdata/tuser      | one row request
// m_axis    | m_axis_tvalid/tready/tdata            | floor and side walls of the row
// cfg       | cfg_valid/cfg_ready/cfg_data          | width_in_use
//
// a first row takes the first-row pass, a middle or last row an open pass and then a merge pass,
// each pass going over the rotating label register, one column per cycle
// a new row is taken once the previous result is in the output register
// reset clears labels to zero, the label counter to one and width_in_use to 32
// a stalled output holds the sequencer before hand-off, not during the passes
`timescale 1ns / 1ps

module maze_row_generator
	import mrg_pkg::*;
#(
	parameter int MAX_COLUMNS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [63:0]      s_axis_tdata,  // floor_random[31:0], side_random[62:32], bit 63 unused
	input  logic [OP_W-1:0]  s_axis_tuser,  // opcode
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // floor_walls[31:0], side_walls[62:32], zero
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	ctl_cmd_t           cmd;
	ctl_sts_t           sts;
	logic [FLOOR_W-1:0] out_floor;
	logic [SIDE_W-1:0]  out_side;

	mrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mrg_dp #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_op     (s_axis_tuser),
		.in_floor  (s_axis_tdata[31:0]),
		.in_side   (s_axis_tdata[62:32]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_floor (out_floor),
		.out_side  (out_side)
	);

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {1'b0, out_side, out_floor};

endmodule

// ----- design/mrg_checker.sv -----
// mrg_checker: port-level checks of the maze row generator, bound to the top level
// depends on mrg_pkg
`timescale 1ns / 1ps

module mrg_checker
	import mrg_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            s_axis_tvalid,
	input logic            s_axis_tready,
	input logic [OP_W-1:0] s_axis_tuser,
	input logic            m_axis_tvalid,
	input logic            m_axis_tready,
	input logic [63:0]     m_axis_tdata
);

	// output held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer dropped or changed under stall");

	// a real row keeps the input side busy
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_SKIP |=> !s_axis_tready)
		else $error("input taken while a row is in work");

	// ignored opcode leaves the input side open
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_SKIP
		|=> s_axis_tready && !$rose(m_axis_tvalid))
		else $error("ignored opcode started work");

	// padding bit of the result stays clear
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63] == 1'b0)
		else $error("result padding not zero");

endmodule

bind maze_row_generator mrg_checker u_mrg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
